/* src/ppws_pkg.sv */
`timescale 1ns / 1ps

package ppws_pkg;

  localparam int SETTLE_COUNT       = 10;
  localparam int GAIN_FRACTION_BITS = 8;

  localparam int TARGET_W  = 25;
  localparam int POS_W     = 32;
  localparam int ERR_W     = 32;
  localparam int DIFF_W    = ERR_W + 1;
  localparam int INTEG_W   = 16;
  localparam int TICKS_W   = 4;
  localparam int GAIN_W    = 16;
  localparam int DRIVE_W   = 8;
  localparam int PULSE_W   = 20;
  localparam int DRIVE_MAX = 100;
  localparam int PULSE_SCALE = 10000;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [0:0] {
    MODE_LOAD = 1'b0,
    MODE_TICK = 1'b1
  } ppws_mode_t;

  typedef enum logic [2:0] {
    REG_KP             = 3'd0,
    REG_KI             = 3'd1,
    REG_KD             = 3'd2,
    REG_COUNTS_PER_POS = 3'd3,
    REG_SETTLE_BAND    = 3'd4,
    REG_INTEGRATE_BAND = 3'd5,
    REG_INTEGRAL_LIMIT = 3'd6,
    REG_OUTPUT_LIMIT   = 3'd7
  } ppws_reg_t;

  typedef struct packed {
    ppws_mode_t         mode;
    logic [7:0]         target_slot;
    logic signed [15:0] encoder_delta;
  } ppws_in_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      forward;
    logic [PULSE_W-1:0]        pulse_ns;
    logic                      position_ok;
  } ppws_out_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp_q8;
    logic [GAIN_W-1:0] ki_q8;
    logic [GAIN_W-1:0] kd_q8;
    logic [15:0]       counts_per_position;
    logic [7:0]        settle_band;
    logic [15:0]       integrate_band;
    logic [14:0]       integral_limit;
    logic [6:0]        output_limit;
  } ppws_cfg_t;

  typedef struct packed {
    logic                      settle;
    logic signed [ERR_W-1:0]   error;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [INTEG_W-1:0] integ;
  } ppws_work_t;

  localparam ppws_cfg_t CFG_RESET = '{
    kp_q8:               16'd90,
    ki_q8:               16'd13,
    kd_q8:               16'd0,
    counts_per_position: 16'd290,
    settle_band:         8'd5,
    integrate_band:      16'd30,
    integral_limit:      15'd1000,
    output_limit:        7'd30
  };

endpackage

/* src/ppws_front.sv */
`timescale 1ns / 1ps

module ppws_front import ppws_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ppws_cfg_t  cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  ppws_in_t   in_data,
  output logic       push,
  output ppws_work_t push_data,
  input  logic       full
);

  localparam int INT_ACC_W = INTEG_W + 2;

  logic [TARGET_W-1:0]       target;
  logic [POS_W-1:0]          position;
  logic                      a_valid;
  ppws_mode_t                a_mode;
  logic signed [ERR_W-1:0]   a_error;

  logic                      armed;
  logic [TICKS_W-1:0]        settle_ticks;
  logic signed [ERR_W-1:0]   error_now;
  logic signed [INTEG_W-1:0] integral;

  logic                      armed_next;
  logic [TICKS_W-1:0]        settle_ticks_next;
  logic signed [ERR_W-1:0]   error_now_next;
  logic signed [INTEG_W-1:0] integral_next;

  logic [TARGET_W-1:0]       target_next;
  logic [POS_W-1:0]          delta_ext;
  logic [POS_W-1:0]          position_next;
  logic [ERR_W-1:0]          error_calc;

  logic                      a_work;
  logic                      a_take;
  logic                      accept;

  logic signed [ERR_W-1:0]     sb;
  logic signed [ERR_W-1:0]     ib;
  logic                        in_settle;
  logic                        in_integrate;
  logic [TICKS_W-1:0]          ticks_inc;
  logic                        settle_hit;
  logic signed [INT_ACC_W-1:0] acc;
  logic signed [INT_ACC_W-1:0] lim;
  logic signed [INT_ACC_W-1:0] acc_clamped;
  logic signed [INTEG_W-1:0]   integ_new;

  assign target_next   = TARGET_W'(24'(in_data.target_slot) * 24'(cfg.counts_per_position));
  assign delta_ext     = {{(POS_W-16){in_data.encoder_delta[15]}}, in_data.encoder_delta};
  assign position_next = position + delta_ext;
  assign error_calc    = POS_W'(target) - position - delta_ext;

  assign a_work   = a_valid && (a_mode == MODE_TICK) && armed;
  assign a_take   = a_valid && (!a_work || !full);
  assign in_ready = !a_valid || a_take;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      target   <= '0;
      position <= '0;
    end else begin
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (accept) begin
        if (in_data.mode == MODE_LOAD) begin
          target <= target_next;
        end else begin
          position <= position_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_mode  <= in_data.mode;
      a_error <= signed'(error_calc);
    end
  end

  assign sb           = ERR_W'(cfg.settle_band);
  assign ib           = ERR_W'(cfg.integrate_band);
  assign in_settle    = (a_error < sb) && (a_error > -sb);
  assign in_integrate = (a_error < ib) && (a_error > -ib);
  assign ticks_inc    = settle_ticks + TICKS_W'(1);
  assign settle_hit   = in_settle && (ticks_inc == TICKS_W'(SETTLE_COUNT));

  assign acc = INT_ACC_W'(integral) + INT_ACC_W'(signed'(a_error[INTEG_W:0]));
  assign lim = INT_ACC_W'(cfg.integral_limit);

  always_comb begin
    priority if (acc > lim) begin
      acc_clamped = lim;
    end else if (acc < -lim) begin
      acc_clamped = -lim;
    end else begin
      acc_clamped = acc;
    end
  end

  assign integ_new = in_integrate ? acc_clamped[INTEG_W-1:0] : '0;

  assign push             = a_take && a_work;
  assign push_data.settle = settle_hit;
  assign push_data.error  = a_error;
  assign push_data.diff   = DIFF_W'(a_error) - DIFF_W'(error_now);
  assign push_data.integ  = integ_new;

  always_comb begin
    armed_next        = armed;
    settle_ticks_next = settle_ticks;
    error_now_next    = error_now;
    integral_next     = integral;
    if (a_take) begin
      if (a_mode == MODE_LOAD) begin
        armed_next = 1'b1;
      end else if (armed) begin
        if (settle_hit) begin
          armed_next        = 1'b0;
          settle_ticks_next = '0;
          error_now_next    = '0;
          integral_next     = '0;
        end else begin
          settle_ticks_next = in_settle ? ticks_inc : '0;
          error_now_next    = a_error;
          integral_next     = integ_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed        <= 1'b0;
      settle_ticks <= '0;
      error_now    <= '0;
      integral     <= '0;
    end else begin
      armed        <= armed_next;
      settle_ticks <= settle_ticks_next;
      error_now    <= error_now_next;
      integral     <= integral_next;
    end
  end

endmodule

/* src/ppws_queue.sv */
`timescale 1ns / 1ps

module ppws_queue import ppws_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  ppws_work_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output ppws_work_t head
);

  ppws_work_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

/* src/ppws_back.sv */
`timescale 1ns / 1ps

module ppws_back import ppws_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ppws_cfg_t  cfg,
  input  logic       q_valid,
  input  ppws_work_t head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output ppws_out_t  out_data
);

  localparam int K_W   = GAIN_W + 1;
  localparam int P_W   = K_W + ERR_W;
  localparam int I_W   = K_W + INTEG_W;
  localparam int D_W   = K_W + DIFF_W;
  localparam int SUM_W = D_W + 2;
  localparam int Q_W   = SUM_W - GAIN_FRACTION_BITS;
  localparam logic [SUM_W-1:0] BIAS = SUM_W'((1 << GAIN_FRACTION_BITS) - 1);

  logic                      adv;
  logic signed [K_W-1:0]     kp_s;
  logic signed [K_W-1:0]     ki_s;
  logic signed [K_W-1:0]     kd_s;

  logic                      s1_valid;
  logic                      s1_settle;
  logic signed [P_W-1:0]     s1_p;
  logic signed [I_W-1:0]     s1_i;
  logic signed [D_W-1:0]     s1_d;

  logic                      s2_valid;
  logic                      s2_settle;
  logic signed [SUM_W-1:0]   s2_sum;

  logic                      s3_valid;
  logic                      s3_settle;
  logic signed [DRIVE_W-1:0] s3_drive;

  logic signed [SUM_W-1:0]   bias_add;
  logic signed [SUM_W-1:0]   biased;
  logic signed [Q_W-1:0]     quot;
  logic [6:0]                lim_eff;
  logic signed [Q_W-1:0]     lim_q;
  logic signed [Q_W-1:0]     clamped;
  logic signed [DRIVE_W-1:0] drive_next;
  logic [DRIVE_W-1:0]        drive_neg;
  logic [6:0]                drive_mag;

  assign adv  = !out_valid || out_ready;
  assign pop  = adv && q_valid;
  assign kp_s = {1'b0, cfg.kp_q8};
  assign ki_s = {1'b0, cfg.ki_q8};
  assign kd_s = {1'b0, cfg.kd_q8};

  assign bias_add = s2_sum[SUM_W-1] ? BIAS : '0;
  assign biased   = s2_sum + bias_add;
  assign quot     = Q_W'(biased >>> GAIN_FRACTION_BITS);
  assign lim_eff  = (cfg.output_limit > 7'(DRIVE_MAX)) ? 7'(DRIVE_MAX) : cfg.output_limit;
  assign lim_q    = Q_W'(lim_eff);

  always_comb begin
    priority if (quot > lim_q) begin
      clamped = lim_q;
    end else if (quot < -lim_q) begin
      clamped = -lim_q;
    end else begin
      clamped = quot;
    end
  end

  assign drive_next = s2_settle ? '0 : clamped[DRIVE_W-1:0];
  assign drive_neg  = -s3_drive;
  assign drive_mag  = s3_drive[DRIVE_W-1] ? drive_neg[6:0] : s3_drive[6:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= q_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_settle <= head.settle;
      s1_p      <= kp_s * head.error;
      s1_i      <= ki_s * head.integ;
      s1_d      <= kd_s * head.diff;

      s2_settle <= s1_settle;
      s2_sum    <= SUM_W'(s1_p) + SUM_W'(s1_i) + SUM_W'(s1_d);

      s3_settle <= s2_settle;
      s3_drive  <= drive_next;

      out_data.drive       <= s3_drive;
      out_data.forward     <= !s3_drive[DRIVE_W-1];
      out_data.pulse_ns    <= PULSE_W'(drive_mag) * PULSE_W'(PULSE_SCALE);
      out_data.position_ok <= s3_settle;
    end
  end

endmodule

/* src/position_pid_with_settle.sv */
`timescale 1ns / 1ps

// channel  direction  beat                             accepted when
// in       input      ppws_in_t  (mode, slot, delta)   in_valid && in_ready
// out      output     ppws_out_t (drive, dir, pulse)   out_valid && out_ready
// cfg      input      cfg_index (3b), cfg_data (16b)   cfg_valid && cfg_ready
//
// One input beat per cycle while in_ready is high. A control tick on an armed loop
// passes through the classify stage, four-entry queue, gain multiply, sum,
// scale and clamp, and output register. Loads and disarmed ticks give no result.
// Synchronous reset restores the register defaults and disarms the loop.
// A stalled output freezes the back pipeline; the queue absorbs four ticks and
// the classify stage one more before in_ready drops. cfg_ready is always high.

module position_pid_with_settle import ppws_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ppws_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output ppws_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ppws_cfg_t  cfg;
  logic       push;
  ppws_work_t push_data;
  logic       full;
  logic       pop;
  logic       empty;
  ppws_work_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ppws_reg_t'(cfg_index))
        REG_KP:             cfg.kp_q8               <= cfg_data;
        REG_KI:             cfg.ki_q8               <= cfg_data;
        REG_KD:             cfg.kd_q8               <= cfg_data;
        REG_COUNTS_PER_POS: cfg.counts_per_position <= cfg_data;
        REG_SETTLE_BAND:    cfg.settle_band         <= cfg_data[7:0];
        REG_INTEGRATE_BAND: cfg.integrate_band      <= cfg_data;
        REG_INTEGRAL_LIMIT: cfg.integral_limit      <= cfg_data[14:0];
        REG_OUTPUT_LIMIT:   cfg.output_limit        <= cfg_data[6:0];
        default:            cfg                     <= cfg;
      endcase
    end
  end

  ppws_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  ppws_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  ppws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (!empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("work pushed into a full queue");

  a_settle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.position_ok |->
      out_data.drive == '0 && out_data.forward && out_data.pulse_ns == '0)
    else $error("settle beat carries nonzero drive");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.drive <= 8'sd100 && out_data.drive >= -8'sd100)
    else $error("drive outside +-100");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("back part took an empty queue slot");
`endif

endmodule

/* test/ppws_checker.sv */
`timescale 1ns / 1ps

module ppws_checker import ppws_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  ppws_in_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  ppws_out_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          results_checked,
  output int          settle_hits
);

  ppws_cfg_t                 loop_cfg;
  logic [TARGET_W-1:0]       goal_count;
  logic [POS_W-1:0]          enc_count;
  logic signed [ERR_W-1:0]   err_cur;
  logic signed [ERR_W-1:0]   err_last;
  logic signed [INTEG_W-1:0] err_sum;
  logic [TICKS_W-1:0]        on_target;
  logic                      loop_armed;
  ppws_out_t                 drive_due[$];
  ppws_out_t                 want;
  ppws_out_t                 seen;
  ppws_out_t                 next_out;
  logic [31:0]               mag;
  longint                    acc, lim, e_now, e_old, kp, ki, kd, drv;

  task automatic flag(input string field, input logic signed [63:0] want_v,
                      input logic signed [63:0] got_v);
    fail_count++;
    $error("%s: expected %0d, got %0d", field, want_v, got_v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      loop_cfg = CFG_RESET;
      goal_count = '0;
      enc_count = '0;
      err_cur = '0;
      err_last = '0;
      err_sum = '0;
      on_target = '0;
      loop_armed = 1'b0;
      drive_due.delete();
      pending = 0;
    end else begin
      if (out_valid && out_ready) begin
        seen = out_data;
        results_checked++;
        if (drive_due.size() == 0) begin
          fail_count++;
          $error("drive beat with nothing expected: drive %0d", $signed(seen.drive));
        end else begin
          want = drive_due.pop_front();
          if (seen.drive !== want.drive)
            flag("drive", $signed(want.drive), $signed(seen.drive));
          if (seen.forward !== want.forward)
            flag("forward", want.forward, seen.forward);
          if (seen.pulse_ns !== want.pulse_ns)
            flag("pulse_ns", want.pulse_ns, seen.pulse_ns);
          if (seen.position_ok !== want.position_ok)
            flag("position_ok", want.position_ok, seen.position_ok);
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (ppws_reg_t'(cfg_index))
          REG_KP:             loop_cfg.kp_q8 = cfg_data;
          REG_KI:             loop_cfg.ki_q8 = cfg_data;
          REG_KD:             loop_cfg.kd_q8 = cfg_data;
          REG_COUNTS_PER_POS: loop_cfg.counts_per_position = cfg_data;
          REG_SETTLE_BAND:    loop_cfg.settle_band = cfg_data[7:0];
          REG_INTEGRATE_BAND: loop_cfg.integrate_band = cfg_data;
          REG_INTEGRAL_LIMIT: loop_cfg.integral_limit = cfg_data[14:0];
          REG_OUTPUT_LIMIT:   loop_cfg.output_limit = cfg_data[6:0];
        endcase
      end

      if (in_valid && in_ready) begin
        if (in_data.mode == MODE_LOAD) begin
          goal_count = TARGET_W'(32'(in_data.target_slot) *
                                 32'(loop_cfg.counts_per_position));
          loop_armed = 1'b1;
        end else begin
          enc_count = enc_count + {{16{in_data.encoder_delta[15]}}, in_data.encoder_delta};
          if (loop_armed) begin
            err_last = err_cur;
            err_cur = 32'(goal_count) - enc_count;
            mag = err_cur[ERR_W-1] ? 32'd0 - err_cur : err_cur;
            if (mag < 32'(loop_cfg.settle_band)) on_target = on_target + 1'b1;
            else on_target = '0;
            if (on_target == SETTLE_COUNT) begin
              on_target = '0;
              err_cur = '0;
              err_last = '0;
              err_sum = '0;
              loop_armed = 1'b0;
              settle_hits++;
              next_out.drive = '0;
              next_out.forward = 1'b1;
              next_out.pulse_ns = '0;
              next_out.position_ok = 1'b1;
              drive_due.push_back(next_out);
            end else begin
              e_now = err_cur;
              e_old = err_last;
              if (mag < 32'(loop_cfg.integrate_band)) acc = longint'(err_sum) + e_now;
              else acc = 0;
              lim = loop_cfg.integral_limit;
              if (acc > lim) acc = lim;
              else if (acc < -lim) acc = -lim;
              err_sum = acc[INTEG_W-1:0];
              kp = loop_cfg.kp_q8;
              ki = loop_cfg.ki_q8;
              kd = loop_cfg.kd_q8;
              acc = kp * e_now + ki * err_sum + kd * (e_now - e_old);
              drv = acc / (longint'(1) << GAIN_FRACTION_BITS);
              lim = loop_cfg.output_limit;
              if (lim > DRIVE_MAX) lim = DRIVE_MAX;
              if (drv > lim) drv = lim;
              else if (drv < -lim) drv = -lim;
              next_out.drive = drv[DRIVE_W-1:0];
              next_out.forward = (drv >= 0);
              next_out.pulse_ns = PULSE_W'((drv < 0 ? -drv : drv) * PULSE_SCALE);
              next_out.position_ok = 1'b0;
              drive_due.push_back(next_out);
            end
          end
        end
      end
      pending = drive_due.size();
    end
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import ppws_pkg::*;

  localparam ppws_cfg_t CFG_TOP = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                    8'hFF, 16'hFFFF, 15'h7FFF, 7'd127};
  localparam ppws_cfg_t CFG_ZERO = '0;
  localparam ppws_cfg_t CFG_KICK = '{
    kp_q8:               16'd0,
    ki_q8:               16'd0,
    kd_q8:               16'hFFFF,
    counts_per_position: 16'd290,
    settle_band:         8'd5,
    integrate_band:      16'd30,
    integral_limit:      15'd1000,
    output_limit:        7'd100
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  ppws_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  ppws_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int fail_count;
  int pending;
  int results_checked;
  int settle_hits;

  int          send_idle = 0;
  int          recv_stall = 0;
  int          beats_sent = 0;
  ppws_cfg_t   cur_cfg = CFG_RESET;
  logic [31:0] goal = '0;
  logic [31:0] enc_pos = '0;

  position_pid_with_settle dut (.*);
  ppws_checker chk (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall);

  function automatic ppws_in_t load_beat(input logic [7:0] slot);
    ppws_in_t b;
    b.mode = MODE_LOAD;
    b.target_slot = slot;
    b.encoder_delta = 16'($urandom);
    return b;
  endfunction

  function automatic ppws_in_t tick_beat(input logic signed [15:0] delta);
    ppws_in_t b;
    b.mode = MODE_TICK;
    b.target_slot = 8'($urandom);
    b.encoder_delta = delta;
    return b;
  endfunction

  // delta that leaves the error at offs, within the 16-bit range
  function automatic logic signed [15:0] aim_delta(input int offs);
    longint d;
    d = longint'($signed(goal - enc_pos)) - offs;
    if (d > 32767) d = 32767;
    else if (d < -32768) d = -32768;
    return 16'(d);
  endfunction

  task automatic push_beat(input ppws_in_t b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    if (b.mode == MODE_LOAD)
      goal = 32'(b.target_slot) * 32'(cur_cfg.counts_per_position);
    else
      enc_pos = enc_pos + {{16{b.encoder_delta[15]}}, b.encoder_delta};
  endtask

  // hold the input until every expected beat is out, then let the pipe empty
  task automatic wait_quiet(input int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(input ppws_reg_t idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_settings(input ppws_cfg_t c);
    wait_quiet(20);
    write_reg(REG_KP, c.kp_q8);
    write_reg(REG_KI, c.ki_q8);
    write_reg(REG_KD, c.kd_q8);
    write_reg(REG_COUNTS_PER_POS, c.counts_per_position);
    write_reg(REG_SETTLE_BAND, 16'(c.settle_band));
    write_reg(REG_INTEGRATE_BAND, c.integrate_band);
    write_reg(REG_INTEGRAL_LIMIT, 16'(c.integral_limit));
    write_reg(REG_OUTPUT_LIMIT, 16'(c.output_limit));
    cfg_valid <= 1'b0;
    cur_cfg = c;
  endtask

  initial begin
    ppws_cfg_t s;
    ppws_in_t  b;
    int        n;
    int        k;
    int        bw;
    int        offs;
    bit        paused;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // move the position while disarmed, then kick the derivative term hard
    load_settings(CFG_KICK);
    repeat (2) push_beat(tick_beat(16'sh8000));
    push_beat(load_beat(8'd0));
    repeat (4) push_beat(tick_beat(16'sh8000));
    push_beat(tick_beat(16'sd0));
    push_beat(tick_beat(16'sd1));
    push_beat(tick_beat(-16'sd1));
    repeat (4) push_beat(tick_beat(16'sh7FFF));

    load_settings(CFG_RESET);
    push_beat(load_beat(8'd255));
    push_beat(tick_beat(16'sd0));
    repeat (3) push_beat(tick_beat(16'sh7FFF));
    push_beat(load_beat(8'd1));
    push_beat(tick_beat(aim_delta(0)));
    push_beat(tick_beat(aim_delta(5)));
    for (int i = 0; i < 10; i++) push_beat(tick_beat(aim_delta((i % 9) - 4)));
    push_beat(tick_beat(16'sh8000));

    for (int p = 0; p < 8; p++) begin
      if (p == 1) load_settings(CFG_TOP);
      else if (p == 2) load_settings(CFG_ZERO);
      else if (p > 2) begin
        s.kp_q8 = 16'($urandom_range(0, 2000));
        s.ki_q8 = 16'($urandom_range(0, 400));
        s.kd_q8 = 16'($urandom_range(0, 3000));
        s.counts_per_position = 16'($urandom_range(1, 600));
        s.settle_band = 8'($urandom_range(1, 40));
        s.integrate_band = 16'($urandom_range(0, 400));
        s.integral_limit = 15'($urandom_range(0, 2000));
        s.output_limit = 7'($urandom_range(0, 127));
        load_settings(s);
      end
      case (p % 4)
        0: begin
          send_idle = 0;
          recv_stall = 0;
        end
        1: begin
          send_idle = 52;
          recv_stall = 0;
        end
        2: begin
          send_idle = 0;
          recv_stall = 52;
        end
        default: begin
          send_idle = 28;
          recv_stall = 28;
        end
      endcase

      n = 0;
      paused = 1'b0;
      while (n < 156) begin
        if (!paused && n >= 78) begin
          wait_quiet(0);
          paused = 1'b1;
        end
        if ($urandom_range(99) < 15) begin
          b.mode = ppws_mode_t'($urandom_range(1));
          b.target_slot = 8'($urandom);
          b.encoder_delta = 16'($urandom);
          push_beat(b);
          n++;
        end else begin
          if (cur_cfg.counts_per_position > 1000 && $urandom_range(9) != 0)
            push_beat(load_beat(8'($urandom_range(3))));
          else
            push_beat(load_beat(8'($urandom)));
          n++;
          k = 0;
          while (k < 40 && ($signed(goal - enc_pos) > 32767 ||
                            $signed(goal - enc_pos) < -32768)) begin
            push_beat(tick_beat(aim_delta(0)));
            n++;
            k++;
          end
          bw = cur_cfg.settle_band;
          push_beat(tick_beat(aim_delta(int'($urandom_range(8 * bw + 100)) - 4 * bw - 50)));
          n++;
          repeat ($urandom_range(6, 14)) begin
            if ($urandom_range(19) == 0) offs = int'($urandom_range(2 * bw + 40)) - bw - 20;
            else if (bw == 0) offs = 0;
            else offs = int'($urandom_range(2 * bw - 2)) - (bw - 1);
            if ($urandom_range(29) == 0) push_beat(load_beat(8'($urandom)));
            else push_beat(tick_beat(aim_delta(offs)));
            n++;
          end
        end
      end
    end

    wait_quiet(20);
    $display("run: %0d input beats, %0d drive beats checked, %0d settle events",
             beats_sent, results_checked, settle_hits);
    $display("run: disarmed ticks, full-scale deltas, extreme and zero gains, four pacing mixes");
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* filelist.f */
src/ppws_pkg.sv
src/ppws_front.sv
src/ppws_queue.sv
src/ppws_back.sv
src/position_pid_with_settle.sv
test/ppws_checker.sv
test/tb_top.sv
